FILE: rtl/psbs_pkg.sv
// Package for the prefix sum bucket search block.
// Holds the request codes, controller states and fixed field widths.
// No dependencies.
`default_nettype none

package psbs_pkg;

  localparam int unsigned LABEL_W = 24;
  localparam int unsigned BKT_W   = 11;

  localparam logic [LABEL_W-1:0] LABEL_MAX   = 24'hFF_FFFF;
  localparam logic [LABEL_W-1:0] FIRST_LABEL = 24'd1;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/psbs_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on psbs_pkg for the field widths.
`default_nettype none

interface psbs_in_if
  import psbs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [LABEL_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface psbs_out_if
  import psbs_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [BKT_W-1:0] bucket_number;
  logic             found;

  modport source (output valid, output bucket_number, output found, input ready);
  modport sink   (input valid, input bucket_number, input found, output ready);
endinterface

`default_nettype wire

FILE: rtl/psbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; contents are undefined until written.
`default_nettype none

module psbs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/prefix_sum_bucket_search.sv
// Prefix sum bucket search: loads, clears and binary-searched label queries.
// Loads and clears are done as their beat is accepted. A query runs a binary search with
// one table read per halving step through the single RAM read port.
// A query outside the loaded range, or on a one-bucket table, answers without a search.
// Synchronous active-low reset empties the table and sets the running total to 1;
// the start table RAM itself is not cleared. Depends on psbs_pkg, psbs_if and psbs_ram.
`default_nettype none

module prefix_sum_bucket_search
  import psbs_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 1024
) (
  input wire logic  clk,
  input wire logic  rst_n,
  psbs_in_if.sink   in_bus,
  psbs_out_if.source out_bus
);

  localparam int unsigned AW = $clog2(MAX_BUCKETS);
  localparam int unsigned CW = $clog2(MAX_BUCKETS + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]      count_r, count_nxt;
  logic [LABEL_W-1:0] total_r, total_nxt;
  logic [CW-1:0]      low_r, low_nxt;
  logic [CW-1:0]      high_r, high_nxt;
  logic [CW-1:0]      mid_r, mid_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic [BKT_W-1:0]   res_bkt_r, res_bkt_nxt;
  logic               res_found_r, res_found_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BKT_W-1:0]   out_bkt_r, out_bkt_nxt;
  logic               out_found_r, out_found_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [LABEL_W-1:0] ram_rdata;

  logic               in_fire;
  logic               out_free;
  logic               trivial;
  logic [LABEL_W:0]   load_sum;
  logic               go_right;
  logic [CW-1:0]      low_new, high_new;
  logic [CW:0]        span_sum;
  logic [CW:0]        low_inc;
  logic [31:0]        bkt_wide;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);

  assign out_bus.valid         = out_valid_r;
  assign out_bus.bucket_number = out_bkt_r;
  assign out_bus.found         = out_found_r;

  assign trivial  = (count_r == '0) || (in_bus.value == '0) || (in_bus.value >= total_r);
  assign load_sum = {1'b0, total_r} + {1'b0, in_bus.value};

  assign go_right = (ram_rdata <= label_r);
  assign low_new  = go_right ? mid_r : low_r;
  assign high_new = go_right ? high_r : mid_r;
  assign span_sum = {1'b0, low_new} + {1'b0, high_new};
  assign low_inc  = {1'b0, low_new} + (CW+1)'(1);
  assign bkt_wide = 32'(low_new) + 32'd1;

  psbs_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (MAX_BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (total_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_bus.req_type == REQ_QUERY)) begin
          if (trivial || (count_r == CW'(1))) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (!(low_inc < {1'b0, high_new})) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    label_nxt     = label_r;
    res_bkt_nxt   = res_bkt_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_bkt_nxt   = out_bkt_r;
    out_found_nxt = out_found_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_raddr     = mid_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_bus.req_type)
            REQ_LOAD: begin
              if (count_r != CW'(MAX_BUCKETS)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                total_nxt = load_sum[LABEL_W] ? LABEL_MAX : load_sum[LABEL_W-1:0];
              end
            end
            REQ_QUERY: begin
              label_nxt     = in_bus.value;
              low_nxt       = '0;
              high_nxt      = count_r;
              mid_nxt       = count_r >> 1;
              ram_raddr     = mid_nxt[AW-1:0];
              res_bkt_nxt   = trivial ? '0 : BKT_W'(1);
              res_found_nxt = !trivial;
            end
            REQ_CLEAR: begin
              count_nxt = '0;
              total_nxt = FIRST_LABEL;
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        low_nxt       = low_new;
        high_nxt      = high_new;
        mid_nxt       = span_sum[CW:1];
        ram_raddr     = mid_nxt[AW-1:0];
        res_bkt_nxt   = bkt_wide[BKT_W-1:0];
        res_found_nxt = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bkt_nxt   = res_bkt_r;
          out_found_nxt = res_found_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= FIRST_LABEL;
      low_r       <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r       <= mid_nxt;
    label_r     <= label_nxt;
    res_bkt_r   <= res_bkt_nxt;
    res_found_r <= res_found_nxt;
    out_bkt_r   <= out_bkt_nxt;
    out_found_r <= out_found_nxt;
  end

  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> ((low_r < mid_r) && (mid_r < high_r) && (high_r <= count_r)))
    else $error("search probe outside its bounds");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BUCKETS))
    else $error("bucket count exceeds table depth");

  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    total_r != '0)
    else $error("running total dropped below the first label");

  a_found_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r == (out_bkt_r != '0)))
    else $error("found flag disagrees with bucket number");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for prefix_sum_bucket_search: loads, queries, clears and unused requests.
// A scoreboard class predicts each query result; tasks drive requests, a process takes results.
// Depends on psbs_pkg, psbs_if and the RTL of the block.

module testbench;
  import psbs_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [BKT_W-1:0]   bucket;
    logic               hit;
  } lookup_t;

  class bucket_scoreboard;
    logic [LABEL_W-1:0] bucket_start [TABLE_DEPTH];
    int unsigned        loaded;
    logic [LABEL_W-1:0] next_label;
    lookup_t            pending_lookups [$];
    int unsigned        mismatches;

    function new();
      loaded = 0;
      next_label = FIRST_LABEL;
      mismatches = 0;
    endfunction

    function lookup_t locate(logic [LABEL_W-1:0] label);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned number;
      lookup_t r;
      r = '0;
      r.label = label;
      if (loaded == 0 || label < bucket_start[0] || label >= next_label) begin
        return r;
      end
      lo = 0;
      hi = loaded;
      while (lo + 1 < hi) begin
        mid = (lo + hi) >> 1;
        if (bucket_start[mid] <= label) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      number = lo + 1;
      r.bucket = number[BKT_W-1:0];
      r.hit = 1'b1;
      return r;
    endfunction

    function void note_request(req_t kind, logic [LABEL_W-1:0] value);
      logic [LABEL_W:0] sum;
      case (kind)
        REQ_LOAD: begin
          if (loaded < TABLE_DEPTH) begin
            bucket_start[loaded] = next_label;
            loaded++;
            sum = {1'b0, next_label} + {1'b0, value};
            next_label = (sum > {1'b0, LABEL_MAX}) ? LABEL_MAX : sum[LABEL_W-1:0];
          end
        end
        REQ_QUERY: begin
          pending_lookups = {pending_lookups, locate(value)};
        end
        REQ_CLEAR: begin
          loaded = 0;
          next_label = FIRST_LABEL;
        end
        REQ_NONE: begin
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) begin
        $display("MISMATCH: %s", what);
      end
    endtask

    task check_result(logic [BKT_W-1:0] bucket, logic hit);
      lookup_t want;
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result bucket %0d found %b with no query waiting",
                                  bucket, hit));
        return;
      end
      want = pending_lookups.pop_front();
      if (bucket !== want.bucket) begin
        report_mismatch($sformatf("label %0d: bucket_number %0d, expected %0d",
                                  want.label, bucket, want.bucket));
      end
      if (hit !== want.hit) begin
        report_mismatch($sformatf("label %0d: found %b, expected %b",
                                  want.label, hit, want.hit));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  bit          tx_calm = 1'b0;
  bucket_scoreboard sb;

  psbs_in_if  in_bus ();
  psbs_out_if out_bus ();

  prefix_sum_bucket_search #(
    .MAX_BUCKETS(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(input req_t kind, input logic [LABEL_W-1:0] value);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.req_type = kind;
    in_bus.value = value;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_request(kind, value);
    if (kind != REQ_NONE) begin
      sent_items++;
    end
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_bus.valid = 1'b0;
    while (sb.pending_lookups.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [LABEL_W-1:0] random_word();
    logic [31:0] w;
    w = $urandom;
    return w[LABEL_W-1:0];
  endfunction

  function automatic logic [LABEL_W-1:0] draw_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return '0;
    end else if (r < 70) begin
      return LABEL_W'($urandom_range(1, 16));
    end else if (r < 90) begin
      return LABEL_W'($urandom_range(17, 5000));
    end else if (r < 97) begin
      return random_word();
    end
    return LABEL_MAX;
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    int unsigned r;
    int unsigned idx;
    logic [LABEL_W-1:0] base;
    r = $urandom_range(0, 9);
    if (sb.loaded == 0 || r == 0) begin
      return random_word();
    end
    idx = $urandom_range(0, sb.loaded - 1);
    base = sb.bucket_start[idx];
    case (r)
      1: return sb.next_label;
      2: return sb.next_label - 1'b1;
      3: return base - 1'b1;
      4, 5: return base;
      default: return base + LABEL_W'($urandom_range(0, 8));
    endcase
  endfunction

  // Results are taken with a random number of stall cycles before each beat,
  // broken up now and then by a stretch of back-to-back acceptance.
  initial begin : result_sink
    int unsigned stall;
    int unsigned calm_left;
    calm_left = 0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          calm_left = $urandom_range(10, 40);
        end
        stall = $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      sb.check_result(out_bus.bucket_number, out_bus.found);
      @(negedge clk);
    end
  end

  initial begin : request_source
    int unsigned loads;
    int unsigned queries;
    int unsigned random_goal;
    sb = new();
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_NONE;
    in_bus.value = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty table, empty buckets, boundaries and saturation.
    send_request(REQ_QUERY, 24'd1);
    send_request(REQ_QUERY, 24'd0);
    send_request(REQ_LOAD, 24'd0);
    send_request(REQ_LOAD, 24'd5);
    send_request(REQ_LOAD, 24'd0);
    send_request(REQ_LOAD, 24'd3);
    send_request(REQ_QUERY, 24'd0);
    send_request(REQ_QUERY, 24'd1);
    send_request(REQ_QUERY, 24'd5);
    send_request(REQ_QUERY, 24'd6);
    send_request(REQ_QUERY, 24'd8);
    send_request(REQ_QUERY, 24'd9);
    send_request(REQ_NONE, LABEL_MAX);
    send_request(REQ_LOAD, LABEL_MAX);
    send_request(REQ_QUERY, LABEL_MAX - 1'b1);
    send_request(REQ_QUERY, LABEL_MAX);
    send_request(REQ_LOAD, 24'd7);
    send_request(REQ_QUERY, LABEL_MAX);
    send_request(REQ_CLEAR, LABEL_MAX);
    send_request(REQ_QUERY, 24'd1);
    send_request(REQ_LOAD, 24'd1);
    send_request(REQ_QUERY, 24'd1);
    send_request(REQ_QUERY, 24'd2);
    send_request(REQ_NONE, 24'd1);
    wait_for_results();

    // Fill the table to its depth, then check that further loads are dropped.
    send_request(REQ_CLEAR, random_word());
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      send_request(REQ_LOAD, LABEL_W'($urandom_range(0, 3)));
    end
    send_request(REQ_LOAD, 24'd2);
    send_request(REQ_QUERY, sb.next_label - 1'b1);
    send_request(REQ_LOAD, LABEL_MAX);
    for (int i = 0; i < 5; i++) begin
      send_request(REQ_LOAD, draw_size());
    end
    send_request(REQ_QUERY, sb.next_label - 1'b1);
    send_request(REQ_QUERY, sb.next_label);
    for (int i = 0; i < 25; i++) begin
      send_request(REQ_QUERY, pick_label());
    end
    wait_for_results();

    // Random part: mostly clear, load and query sequences, with some noise beats.
    random_goal = sent_items + RANDOM_ITEMS;
    while (sent_items < random_goal) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) < 7) begin
          send_request(REQ_CLEAR, random_word());
        end
        loads = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        queries = $urandom_range(2, 12);
        for (int i = 0; i < loads; i++) begin
          send_request(REQ_LOAD, draw_size());
        end
        for (int i = 0; i < queries; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_request(req_t'($urandom_range(0, 3)), random_word());
          end
          send_request(REQ_QUERY, pick_label());
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_request(req_t'($urandom_range(0, 3)), random_word());
        end
      end
    end
    tx_calm = 1'b0;
    wait_for_results();
    repeat (30) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending_lookups.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
